@@ rtl/ocr_pkg.sv @@
// Package for the obstacle disk cost rasterizer.
// Holds command and register codes, cost constants, unit widths and request and response types.
// No dependencies.
package ocr_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_MARK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] REG_ROBOT_X   = 3'd0;
    localparam logic [2:0] REG_ROBOT_Y   = 3'd1;
    localparam logic [2:0] REG_YAW_COS   = 3'd2;
    localparam logic [2:0] REG_YAW_SIN   = 3'd3;
    localparam logic [2:0] REG_CELL_SIZE = 3'd4;
    localparam logic [2:0] REG_INFLATION = 3'd5;

    localparam logic [6:0]  COST_CURRENT   = 7'd100;
    localparam logic [6:0]  COST_PREDICTED = 7'd90;
    localparam logic [9:0]  CONF_MIN       = 10'd103;
    localparam logic [16:0] MIN_RADIUS     = 17'd154;

    localparam int MUL_AW = 33;
    localparam int MUL_BW = 26;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int DIV_NW = 27;
    localparam int DIV_DW = 16;

    typedef struct packed {
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/ocr_if.sv @@
// Channel interfaces of the obstacle disk cost rasterizer: command, result, config write.
// Valid/ready handshake; a transaction completes when both are high.
// No dependencies.
interface ocr_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic               obstacle_valid;
    logic [9:0]         confidence;
    logic signed [23:0] obstacle_x;
    logic signed [23:0] obstacle_y;
    logic [15:0]        radius;
    logic [15:0]        pred_radius;
    logic               predicted_valid;
    logic signed [23:0] predicted_x;
    logic signed [23:0] predicted_y;
    logic [13:0]        cell_index;
    modport source (output valid, command, obstacle_valid, confidence, obstacle_x, obstacle_y,
                    radius, pred_radius, predicted_valid, predicted_x, predicted_y,
                    cell_index, input ready);
    modport sink (input valid, command, obstacle_valid, confidence, obstacle_x, obstacle_y,
                  radius, pred_radius, predicted_valid, predicted_x, predicted_y,
                  cell_index, output ready);
endinterface

interface ocr_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] cell_cost;
    logic       obstacle_accepted;
    modport source (output valid, cell_cost, obstacle_accepted, input ready);
    modport sink (input valid, cell_cost, obstacle_accepted, output ready);
endinterface

interface ocr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ocr_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on ocr_pkg.
module ocr_mul (
    input  logic                             i_clk,
    input  ocr_pkg::t_mul_req                i_req,
    output logic signed [ocr_pkg::MUL_PW-1:0] o_p
);
    import ocr_pkg::*;

    logic signed [MUL_PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_req.a * i_req.b;
    end

    assign o_p = r_p;

endmodule

@@ rtl/ocr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on ocr_pkg.
module ocr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ocr_pkg::t_div_req i_req,
    output ocr_pkg::t_div_rsp o_rsp
);
    import ocr_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [DIV_DW-1:0] r_dvs, n_dvs;
    logic [DIV_DW:0]   w_trial, w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[DIV_NW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
            n_quo = {r_quo[DIV_NW-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/obstacle_disk_cost_rasterizer.sv @@
// Obstacle disk cost rasterizer: robot-centred cost grid with clear, mark and read commands.
// Clear: one cell per cycle. Mark: per disk a rotation and up to three divisions on the shared
// divider (the radius division is skipped when the centre is off the grid), plus a
// read-modify-write on the grid memory for each cell of the (2r+1)^2 box.
// One transaction at a time. After reset the grid is zeroed by a clearing pass before the
// first command is taken. Depends on ocr_pkg, ocr_if, ocr_mul, ocr_div.
module obstacle_disk_cost_rasterizer #(
    parameter int GRID_WIDTH       = 128,
    parameter int GRID_HEIGHT      = 128,
    parameter int MAX_RADIUS_CELLS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ocr_cmd_if.sink    i_cmd,
    ocr_res_if.source  o_res,
    ocr_cfg_if.sink    i_cfg
);
    import ocr_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int RW    = $clog2(MAX_RADIUS_CELLS + 1) + 1;
    localparam int MXY   = (XW > YW) ? XW : YW;
    localparam int GXW   = ((MXY > RW) ? MXY : RW) + 2;
    localparam int D2W   = 2 * RW;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLEAR = 5'd1;
    localparam logic [4:0] S_READ  = 5'd2;
    localparam logic [4:0] S_RDAT  = 5'd3;
    localparam logic [4:0] S_DISK  = 5'd4;
    localparam logic [4:0] S_M1    = 5'd5;
    localparam logic [4:0] S_M2    = 5'd6;
    localparam logic [4:0] S_M3    = 5'd7;
    localparam logic [4:0] S_M4    = 5'd8;
    localparam logic [4:0] S_DIVX  = 5'd9;
    localparam logic [4:0] S_WDX   = 5'd10;
    localparam logic [4:0] S_DIVY  = 5'd11;
    localparam logic [4:0] S_WDY   = 5'd12;
    localparam logic [4:0] S_DIVR  = 5'd13;
    localparam logic [4:0] S_WDR   = 5'd14;
    localparam logic [4:0] S_SQ1   = 5'd15;
    localparam logic [4:0] S_SQ2   = 5'd16;
    localparam logic [4:0] S_SQ3   = 5'd17;
    localparam logic [4:0] S_CELL  = 5'd18;
    localparam logic [4:0] S_WR    = 5'd19;
    localparam logic [4:0] S_NEXTD = 5'd20;
    localparam logic [4:0] S_DONE  = 5'd21;

    // config registers
    logic signed [23:0] r_robot_x, r_robot_y;
    logic signed [15:0] r_cos, r_sin;
    logic [15:0]        r_cs, r_infl;

    // control
    logic [4:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_silent, n_silent;
    logic          r_second, n_second;
    logic          r_ovalid, n_ovalid;

    // payload
    logic signed [23:0]    r_wx, n_wx, r_wy, n_wy, r_px, n_px, r_py, n_py;
    logic [16:0]           r_r, n_r, r_rp, n_rp;
    logic [6:0]            r_cost, n_cost;
    logic                  r_pv, n_pv;
    logic signed [41:0]    r_acc, n_acc, r_lx, n_lx, r_ly, n_ly;
    logic signed [28:0]    r_cx, n_cx, r_cy, n_cy;
    logic signed [RW-1:0]  r_rc, n_rc, r_i, n_i, r_j, n_j;
    logic [31:0]           r_cs2, n_cs2;
    logic [35:0]           r_r2, n_r2;
    logic                  r_ingrid, n_ingrid;
    logic [AW-1:0]         r_addr, n_addr;
    logic [6:0]            r_res_cost, n_res_cost, r_ocost, n_ocost;
    logic                  r_res_acc, n_res_acc, r_oacc, n_oacc;

    // shared units
    t_mul_req                 w_mreq;
    logic signed [MUL_PW-1:0] w_p;
    t_div_req                 w_dreq;
    t_div_rsp                 w_drsp;

    ocr_mul u_mul (.i_clk(i_clk), .i_req(w_mreq), .o_p(w_p));
    ocr_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // grid memory
    logic [6:0]    r_mem [CELLS];
    logic [6:0]    r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [6:0]    w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // datapath helpers
    logic signed [24:0]        w_dx, w_dy;
    logic signed [MUL_AW-1:0]  w_nsin;
    logic [41:0]               w_abs;
    logic [42:0]               w_nsum;
    logic signed [28:0]        w_cq, w_cen;
    logic                      w_neg;
    logic [DIV_NW-1:0]         w_rq;
    logic signed [GXW-1:0]     w_gx, w_gy;
    logic                      w_in;
    logic [AW-1:0]             w_addr;
    logic [D2W-1:0]            w_d2;
    logic                      w_off;
    logic signed [2*RW-1:0]    w_ii, w_jj;

    assign w_dx   = 25'(r_wx) - 25'(r_robot_x);
    assign w_dy   = 25'(r_wy) - 25'(r_robot_y);
    assign w_nsin = -(MUL_AW'(r_sin));

    assign w_neg  = (r_state == S_DIVX || r_state == S_WDX) ? r_lx[41] : r_ly[41];
    assign w_abs  = (r_state == S_DIVX) ? (r_lx[41] ? 42'(-r_lx) : 42'(r_lx))
                                        : (r_ly[41] ? 42'(-r_ly) : 42'(r_ly));
    assign w_nsum = 43'(w_abs) + (43'(r_cs) << 14);
    assign w_cq   = $signed({2'b00, w_drsp.quotient});
    assign w_cen  = (r_state == S_WDX) ? 29'(GRID_WIDTH / 2) : 29'(GRID_HEIGHT / 2);

    assign w_rq  = w_drsp.quotient;
    assign w_off = r_cx < 0 || r_cy < 0 || r_cx >= 29'(GRID_WIDTH) || r_cy >= 29'(GRID_HEIGHT);

    assign w_gx   = $signed({{(GXW - XW){1'b0}}, r_cx[XW-1:0]}) + GXW'(r_i);
    assign w_gy   = $signed({{(GXW - YW){1'b0}}, r_cy[YW-1:0]}) + GXW'(r_j);
    assign w_in   = w_gx >= 0 && w_gy >= 0 && w_gx < GXW'(GRID_WIDTH) && w_gy < GXW'(GRID_HEIGHT);
    assign w_addr = AW'(w_gy[YW-1:0]) * AW'(GRID_WIDTH) + AW'(w_gx[XW-1:0]);
    assign w_ii   = r_i * r_i;
    assign w_jj   = r_j * r_j;
    assign w_d2   = D2W'($unsigned(w_ii)) + D2W'($unsigned(w_jj));

    always_comb begin
        w_mreq = '0;
        case (r_state)
            S_DISK: begin
                w_mreq.a = MUL_AW'(r_cos);
                w_mreq.b = MUL_BW'(w_dx);
            end
            S_M1: begin
                w_mreq.a = MUL_AW'(r_sin);
                w_mreq.b = MUL_BW'(w_dy);
            end
            S_M2: begin
                w_mreq.a = w_nsin;
                w_mreq.b = MUL_BW'(w_dx);
            end
            S_M3: begin
                w_mreq.a = MUL_AW'(r_cos);
                w_mreq.b = MUL_BW'(w_dy);
            end
            S_SQ1: begin
                w_mreq.a = MUL_AW'({1'b0, r_cs});
                w_mreq.b = MUL_BW'({1'b0, r_cs});
            end
            S_SQ2: begin
                w_mreq.a = MUL_AW'({1'b0, r_r});
                w_mreq.b = MUL_BW'({1'b0, r_r});
            end
            S_CELL: begin
                w_mreq.a = MUL_AW'({1'b0, r_cs2});
                w_mreq.b = MUL_BW'(w_d2);
            end
            default: begin
                w_mreq = '0;
            end
        endcase
    end

    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.divisor  = r_cs;
        w_dreq.dividend = w_nsum[41:15];
        case (r_state)
            S_DIVX, S_DIVY: begin
                w_dreq.start = 1'b1;
            end
            S_DIVR: begin
                w_dreq.start    = !w_off;
                w_dreq.dividend = DIV_NW'(18'(r_r) + 18'(r_cs) - 18'd1);
            end
            default: begin
                w_dreq.start = 1'b0;
            end
        endcase
    end

    logic signed [MUL_PW-1:0] w_r2e;
    logic                     w_hit;
    assign w_r2e = $signed({{(MUL_PW - 36){1'b0}}, r_r2});
    assign w_hit = r_ingrid && (w_p <= w_r2e) && (r_rdata < r_cost);

    assign w_we    = (r_state == S_CLEAR) || (r_state == S_WR && w_hit);
    assign w_waddr = (r_state == S_CLEAR) ? r_cnt : r_addr;
    assign w_wdata = (r_state == S_CLEAR) ? 7'd0 : r_cost;
    assign w_raddr = (r_state == S_CELL) ? w_addr : r_addr;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid             = r_ovalid;
    assign o_res.cell_cost         = r_ocost;
    assign o_res.obstacle_accepted = r_oacc;

    logic [16:0] w_rc0, w_rp0, w_rmax;
    assign w_rc0  = (17'(i_cmd.radius) + 17'(r_infl) < MIN_RADIUS) ? MIN_RADIUS
                  : 17'(i_cmd.radius) + 17'(r_infl);
    assign w_rmax = (i_cmd.pred_radius > i_cmd.radius) ? 17'(i_cmd.pred_radius)
                                                      : 17'(i_cmd.radius);
    assign w_rp0  = (w_rmax + 17'(r_infl) < w_rc0) ? w_rc0 : w_rmax + 17'(r_infl);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_silent   = r_silent;
        n_second   = r_second;
        n_ovalid   = r_ovalid && !o_res.ready;
        n_wx = r_wx; n_wy = r_wy; n_px = r_px; n_py = r_py;
        n_r = r_r; n_rp = r_rp; n_cost = r_cost; n_pv = r_pv;
        n_acc = r_acc; n_lx = r_lx; n_ly = r_ly; n_cx = r_cx; n_cy = r_cy;
        n_rc = r_rc; n_i = r_i; n_j = r_j; n_cs2 = r_cs2; n_r2 = r_r2;
        n_ingrid   = r_ingrid;
        n_addr     = r_addr;
        n_res_cost = r_res_cost;
        n_res_acc  = r_res_acc;
        n_ocost    = r_ocost;
        n_oacc     = r_oacc;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_res_cost = 7'd0;
                    n_res_acc  = 1'b0;
                    n_state    = S_DONE;
                    case (i_cmd.command)
                        CMD_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        CMD_MARK: begin
                            if (i_cmd.obstacle_valid && i_cmd.confidence >= CONF_MIN) begin
                                n_res_acc = 1'b1;
                                n_wx      = i_cmd.obstacle_x;
                                n_wy      = i_cmd.obstacle_y;
                                n_r       = w_rc0;
                                n_cost    = COST_CURRENT;
                                n_px      = i_cmd.predicted_x;
                                n_py      = i_cmd.predicted_y;
                                n_rp      = w_rp0;
                                n_pv      = i_cmd.predicted_valid;
                                n_second  = 1'b0;
                                n_state   = S_DISK;
                            end
                        end
                        CMD_READ: begin
                            n_ingrid = 32'(i_cmd.cell_index) < 32'(CELLS);
                            n_addr   = AW'(i_cmd.cell_index);
                            n_state  = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_silent = 1'b0;
                    n_state  = r_silent ? S_IDLE : S_DONE;
                end
            end
            S_READ: begin
                n_state = S_RDAT;
            end
            S_RDAT: begin
                n_res_cost = r_ingrid ? r_rdata : 7'd0;
                n_state    = S_DONE;
            end
            S_DISK: begin
                n_state = (r_cs == 16'd0) ? S_NEXTD : S_M1;
            end
            S_M1: begin
                n_acc   = 42'(w_p);
                n_state = S_M2;
            end
            S_M2: begin
                n_lx    = r_acc + 42'(w_p);
                n_state = S_M3;
            end
            S_M3: begin
                n_acc   = 42'(w_p);
                n_state = S_M4;
            end
            S_M4: begin
                n_ly    = r_acc + 42'(w_p);
                n_state = S_DIVX;
            end
            S_DIVX: begin
                n_state = S_WDX;
            end
            S_WDX: begin
                if (w_drsp.done) begin
                    n_cx    = w_neg ? w_cen - w_cq : w_cen + w_cq;
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                n_state = S_WDY;
            end
            S_WDY: begin
                if (w_drsp.done) begin
                    n_cy    = w_neg ? w_cen - w_cq : w_cen + w_cq;
                    n_state = S_DIVR;
                end
            end
            S_DIVR: begin
                n_state = w_off ? S_NEXTD : S_WDR;
            end
            S_WDR: begin
                if (w_drsp.done) begin
                    n_rc    = (w_rq > DIV_NW'(MAX_RADIUS_CELLS)) ? RW'(MAX_RADIUS_CELLS)
                                                                : RW'(w_rq);
                    n_state = S_SQ1;
                end
            end
            S_SQ1: begin
                n_state = S_SQ2;
            end
            S_SQ2: begin
                n_cs2   = w_p[31:0];
                n_state = S_SQ3;
            end
            S_SQ3: begin
                n_r2    = w_p[35:0];
                n_i     = -r_rc;
                n_j     = -r_rc;
                n_state = S_CELL;
            end
            S_CELL: begin
                n_ingrid = w_in;
                n_addr   = w_addr;
                n_state  = S_WR;
            end
            S_WR: begin
                n_state = S_CELL;
                if (r_i == r_rc) begin
                    n_i = -r_rc;
                    if (r_j == r_rc) begin
                        n_state = S_NEXTD;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_NEXTD: begin
                if (!r_second && r_pv) begin
                    n_second = 1'b1;
                    n_wx     = r_px;
                    n_wy     = r_py;
                    n_r      = r_rp;
                    n_cost   = COST_PREDICTED;
                    n_state  = S_DISK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_ocost  = r_res_cost;
                    n_oacc   = r_res_acc;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_silent  <= 1'b1;
            r_second  <= 1'b0;
            r_ovalid  <= 1'b0;
            r_robot_x <= '0;
            r_robot_y <= '0;
            r_cos     <= 16'sd32767;
            r_sin     <= '0;
            r_cs      <= 16'd51;
            r_infl    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_silent <= n_silent;
            r_second <= n_second;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_ROBOT_X:   r_robot_x <= i_cfg.data;
                    REG_ROBOT_Y:   r_robot_y <= i_cfg.data;
                    REG_YAW_COS:   r_cos     <= i_cfg.data[15:0];
                    REG_YAW_SIN:   r_sin     <= i_cfg.data[15:0];
                    REG_CELL_SIZE: r_cs      <= i_cfg.data[15:0];
                    REG_INFLATION: r_infl    <= i_cfg.data[15:0];
                    default: begin
                    end
                endcase
            end
        end
        r_wx <= n_wx; r_wy <= n_wy; r_px <= n_px; r_py <= n_py;
        r_r <= n_r; r_rp <= n_rp; r_cost <= n_cost; r_pv <= n_pv;
        r_acc <= n_acc; r_lx <= n_lx; r_ly <= n_ly; r_cx <= n_cx; r_cy <= n_cy;
        r_rc <= n_rc; r_i <= n_i; r_j <= n_j; r_cs2 <= n_cs2; r_r2 <= n_r2;
        r_ingrid   <= n_ingrid;
        r_addr     <= n_addr;
        r_res_cost <= n_res_cost;
        r_res_acc  <= n_res_acc;
        r_ocost    <= n_ocost;
        r_oacc     <= n_oacc;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> r_state == S_IDLE)
        else $error("command ready outside idle");

    a_cell_to_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CELL |=> r_state == S_WR)
        else $error("cell visit did not reach write step");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_WR))
        else $error("grid write outside clear or write step");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

endmodule
